/* src/lsx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsx_pkg
// Shared codes and opcodes for the load/store executor.
// ----------------------------------------------------------------------------
package lsx_pkg;

    // action codes on the input channel
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // 3-bit operand codes
    localparam logic [2:0] R_B   = 3'd0;
    localparam logic [2:0] R_C   = 3'd1;
    localparam logic [2:0] R_D   = 3'd2;
    localparam logic [2:0] R_E   = 3'd3;
    localparam logic [2:0] R_H   = 3'd4;
    localparam logic [2:0] R_L   = 3'd5;
    localparam logic [2:0] R_MHL = 3'd6;
    localparam logic [2:0] R_A   = 3'd7;

    // 2-bit pair codes of PUSH/POP
    localparam logic [1:0] P_BC = 2'd0;
    localparam logic [1:0] P_DE = 2'd1;
    localparam logic [1:0] P_HL = 2'd2;
    localparam logic [1:0] P_AF = 2'd3;

    // opcodes
    localparam logic [7:0] OPC_NOP     = 8'h00;
    localparam logic [7:0] OPC_HALT    = 8'h76;
    localparam logic [7:0] OPC_LD_A_N  = 8'h3E;
    localparam logic [7:0] OPC_ILLEGAL = 8'hD3;
    localparam logic [7:0] OPC_ST_BC   = 8'h02;
    localparam logic [7:0] OPC_ST_DE   = 8'h12;
    localparam logic [7:0] OPC_ST_HLI  = 8'h22;
    localparam logic [7:0] OPC_ST_HLD  = 8'h32;
    localparam logic [7:0] OPC_LD_BC   = 8'h0A;
    localparam logic [7:0] OPC_LD_DE   = 8'h1A;
    localparam logic [7:0] OPC_LD_HLI  = 8'h2A;
    localparam logic [7:0] OPC_LD_HLD  = 8'h3A;
    localparam logic [7:0] OPC_STH_N   = 8'hE0;
    localparam logic [7:0] OPC_STH_C   = 8'hE2;
    localparam logic [7:0] OPC_ST_NN   = 8'hEA;
    localparam logic [7:0] OPC_LDH_N   = 8'hF0;
    localparam logic [7:0] OPC_LDH_C   = 8'hF2;
    localparam logic [7:0] OPC_LD_NN   = 8'hFA;
    localparam logic [7:0] OPC_LDI_BC  = 8'h01;
    localparam logic [7:0] OPC_LDI_DE  = 8'h11;
    localparam logic [7:0] OPC_LDI_HL  = 8'h21;
    localparam logic [7:0] OPC_LDI_SP  = 8'h31;
    localparam logic [7:0] OPC_ST_SP   = 8'h08;
    localparam logic [7:0] OPC_POP_BC  = 8'hC1;
    localparam logic [7:0] OPC_POP_DE  = 8'hD1;
    localparam logic [7:0] OPC_POP_HL  = 8'hE1;
    localparam logic [7:0] OPC_POP_AF  = 8'hF1;
    localparam logic [7:0] OPC_PUSH_BC = 8'hC5;
    localparam logic [7:0] OPC_PUSH_DE = 8'hD5;
    localparam logic [7:0] OPC_PUSH_HL = 8'hE5;
    localparam logic [7:0] OPC_PUSH_AF = 8'hF5;
    localparam logic [7:0] OPC_LD_HLSP = 8'hF8;
    localparam logic [7:0] OPC_LD_SPHL = 8'hF9;

    localparam logic [7:0] HIGH_PAGE = 8'hFF;

endpackage

/* src/lsx_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsx_in_if / lsx_out_if
// Valid/ready channels for the executor's requests and results.
// ----------------------------------------------------------------------------
interface lsx_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;

    modport source (output valid, output op, output addr, output wdata, input ready);
    modport sink   (input valid, input op, input addr, input wdata, output ready);
endinterface

interface lsx_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [15:0] prog_counter;
    logic [15:0] stack_ptr;
    logic [15:0] pair_af;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic        undefined_op;

    modport source (output valid, output read_data, output prog_counter, output stack_ptr,
                    output pair_af, output pair_bc, output pair_de, output pair_hl,
                    output undefined_op, input ready);
    modport sink   (input valid, input read_data, input prog_counter, input stack_ptr,
                    input pair_af, input pair_bc, input pair_de, input pair_hl,
                    input undefined_op, output ready);
endinterface

/* src/cpu_load_store_executor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_load_store_executor_unit
// Reduced SM83 core running load/store instructions against a byte memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request item: op selects a memory byte write, a memory
//   byte read, or the execution of one instruction at PC. o_out returns one
//   item per request with the read byte, PC, SP, the four register pairs and
//   the undefined-opcode flag.
//   All state sits in one single-port synchronous RAM (MEM_BYTES bytes) plus
//   the register file. Each RAM access has the issuing step register the
//   address and its quotient by MEM_BYTES, followed by the RAM cycle.
//   An instruction does up to 4 further accesses after its opcode fetch.
//   One item is in flight at a time; i_in.ready is high only when idle.
//   The result sits in an output register, so a new item is taken while the
//   previous result still waits; if the receiver stalls, the finished item
//   waits in its final state until the output register frees up.
//   Reset clears the registers and the output valid; memory is not cleared.
// ----------------------------------------------------------------------------
module cpu_load_store_executor_unit #(
    parameter int MEM_BYTES = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsx_in_if.sink    i_in,
    lsx_out_if.source o_out
);
    import lsx_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    // reciprocal for address modulo MEM_BYTES; exact for 16-bit addresses
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MEM_BYTES + 64'd1);

    typedef enum logic [3:0] {
        S_IDLE, S_MEM, S_DEC, S_LDR_WR, S_LDA, S_HIGH, S_IMM_LO, S_IMM_HI,
        S_ST_SP_HI, S_POP_LO, S_POP_HI, S_PUSH_LO, S_LDHL_SP, S_FIN
    } t_state;

    // RAM
    logic [7:0] mem [MEM_BYTES];

    // control and register file
    t_state      r_state, n_state;
    t_state      r_ret,   n_ret;
    logic [15:0] r_addr,  n_addr;
    logic [15:0] r_q,     n_q;
    logic        r_we,    n_we;
    logic [7:0]  r_wd,    n_wd;
    logic [7:0]  r_rdata;
    logic [7:0]  r_opc,   n_opc;
    logic [7:0]  r_lo,    n_lo;
    logic [15:0] r_ptr,   n_ptr;
    logic        r_isrd,  n_isrd;
    logic        r_undef, n_undef;
    logic [15:0] r_af, n_af, r_bc, n_bc, r_de, n_de, r_hl, n_hl, r_pc, n_pc, r_sp, n_sp;
    logic        r_ov, n_ov;
    logic [7:0]  r_o_rd, n_o_rd;
    logic [15:0] r_o_pc, n_o_pc, r_o_sp, n_o_sp;
    logic [15:0] r_o_af, n_o_af, r_o_bc, n_o_bc, r_o_de, n_o_de, r_o_hl, n_o_hl;
    logic        r_o_un, n_o_un;

    // access request and register-write request from the sequencer
    logic        c_acc;
    logic        c_we;
    logic [15:0] c_addr;
    logic [7:0]  c_wd;
    logic        c_set;
    logic [2:0]  c_set_code;
    logic [7:0]  c_set_val;
    logic [49:0] c_prod;
    logic [31:0] c_qm;
    logic [15:0] c_rem;
    logic [AW-1:0] c_idx;
    logic [15:0] c_word;
    logic [15:0] c_pair;
    logic [4:0]  c_hsum;
    logic [8:0]  c_csum;

    function automatic logic [7:0] get_r(input logic [2:0] code);
        case (code)
            R_B:     get_r = r_bc[15:8];
            R_C:     get_r = r_bc[7:0];
            R_D:     get_r = r_de[15:8];
            R_E:     get_r = r_de[7:0];
            R_H:     get_r = r_hl[15:8];
            R_L:     get_r = r_hl[7:0];
            default: get_r = r_af[15:8];
        endcase
    endfunction

    // memory index: address minus quotient times size
    assign c_qm  = 32'(r_q) * 32'(MEM_BYTES);
    assign c_rem = r_addr - c_qm[15:0];
    assign c_idx = c_rem[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == S_MEM) begin
            if (r_we) begin
                mem[c_idx] <= r_wd;
            end
            r_rdata <= mem[c_idx];
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.read_data    = r_o_rd;
    assign o_out.prog_counter = r_o_pc;
    assign o_out.stack_ptr    = r_o_sp;
    assign o_out.pair_af      = r_o_af;
    assign o_out.pair_bc      = r_o_bc;
    assign o_out.pair_de      = r_o_de;
    assign o_out.pair_hl      = r_o_hl;
    assign o_out.undefined_op = r_o_un;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;
        n_addr = r_addr;    n_q = r_q;     n_we = r_we;   n_wd = r_wd;
        n_opc = r_opc;      n_lo = r_lo;   n_ptr = r_ptr;
        n_isrd = r_isrd;    n_undef = r_undef;
        n_af = r_af; n_bc = r_bc; n_de = r_de; n_hl = r_hl; n_pc = r_pc; n_sp = r_sp;
        n_ov = r_ov && !o_out.ready;
        n_o_rd = r_o_rd; n_o_pc = r_o_pc; n_o_sp = r_o_sp;
        n_o_af = r_o_af; n_o_bc = r_o_bc; n_o_de = r_o_de; n_o_hl = r_o_hl;
        n_o_un = r_o_un;
        c_acc = 1'b0; c_we = 1'b0; c_addr = r_pc; c_wd = r_af[15:8];
        c_set = 1'b0; c_set_code = r_opc[5:3]; c_set_val = r_rdata;
        c_word = {r_rdata, r_lo};
        c_pair = r_bc;
        c_hsum = 5'(r_sp[3:0]) + 5'(r_rdata[3:0]);
        c_csum = 9'(r_sp[7:0]) + 9'(r_rdata);

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_isrd  = 1'b0;
                    n_undef = 1'b0;
                    n_ret   = S_FIN;
                    case (i_in.op)
                        OP_WRITE: begin
                            c_acc = 1'b1; c_we = 1'b1;
                            c_addr = i_in.addr; c_wd = i_in.wdata;
                        end
                        OP_READ: begin
                            c_acc = 1'b1; c_addr = i_in.addr; n_isrd = 1'b1;
                        end
                        OP_EXEC: begin
                            c_acc = 1'b1; c_addr = r_pc;
                            n_pc = r_pc + 16'd1; n_ret = S_DEC;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_MEM: n_state = r_ret;
            S_DEC: begin
                n_opc   = r_rdata;
                n_state = S_FIN;
                n_ret   = S_FIN;
                if (r_rdata[7:6] == 2'b01 && r_rdata != OPC_HALT) begin
                    // LD r,r'
                    if (r_rdata[2:0] == R_MHL) begin
                        c_acc = 1'b1; c_addr = r_hl; n_ret = S_LDR_WR;
                    end else if (r_rdata[5:3] == R_MHL) begin
                        c_acc = 1'b1; c_we = 1'b1; c_addr = r_hl;
                        c_wd = get_r(r_rdata[2:0]);
                    end else begin
                        c_set = 1'b1; c_set_code = r_rdata[5:3];
                        c_set_val = get_r(r_rdata[2:0]);
                    end
                end else if (r_rdata[7:6] == 2'b00 && r_rdata[2:0] == 3'd6) begin
                    // LD r,n
                    c_acc = 1'b1; c_addr = r_pc; n_pc = r_pc + 16'd1; n_ret = S_LDR_WR;
                end else begin
                    case (r_rdata)
                        OPC_NOP: ;
                        OPC_ST_BC: begin
                            c_acc = 1'b1; c_we = 1'b1; c_addr = r_bc;
                        end
                        OPC_ST_DE: begin
                            c_acc = 1'b1; c_we = 1'b1; c_addr = r_de;
                        end
                        OPC_ST_HLI: begin
                            c_acc = 1'b1; c_we = 1'b1; c_addr = r_hl; n_hl = r_hl + 16'd1;
                        end
                        OPC_ST_HLD: begin
                            c_acc = 1'b1; c_we = 1'b1; c_addr = r_hl; n_hl = r_hl - 16'd1;
                        end
                        OPC_LD_BC: begin
                            c_acc = 1'b1; c_addr = r_bc; n_ret = S_LDA;
                        end
                        OPC_LD_DE: begin
                            c_acc = 1'b1; c_addr = r_de; n_ret = S_LDA;
                        end
                        OPC_LD_HLI: begin
                            c_acc = 1'b1; c_addr = r_hl; n_hl = r_hl + 16'd1; n_ret = S_LDA;
                        end
                        OPC_LD_HLD: begin
                            c_acc = 1'b1; c_addr = r_hl; n_hl = r_hl - 16'd1; n_ret = S_LDA;
                        end
                        OPC_STH_N, OPC_LDH_N: begin
                            c_acc = 1'b1; n_pc = r_pc + 16'd1; n_ret = S_HIGH;
                        end
                        OPC_STH_C: begin
                            c_acc = 1'b1; c_we = 1'b1; c_addr = {HIGH_PAGE, r_bc[7:0]};
                        end
                        OPC_LDH_C: begin
                            c_acc = 1'b1; c_addr = {HIGH_PAGE, r_bc[7:0]}; n_ret = S_LDA;
                        end
                        OPC_ST_NN, OPC_LD_NN, OPC_LDI_BC, OPC_LDI_DE, OPC_LDI_HL,
                        OPC_LDI_SP, OPC_ST_SP: begin
                            c_acc = 1'b1; n_pc = r_pc + 16'd1; n_ret = S_IMM_LO;
                        end
                        OPC_POP_BC, OPC_POP_DE, OPC_POP_HL, OPC_POP_AF: begin
                            c_acc = 1'b1; c_addr = r_sp; n_sp = r_sp + 16'd1;
                            n_ret = S_POP_LO;
                        end
                        OPC_PUSH_BC, OPC_PUSH_DE, OPC_PUSH_HL, OPC_PUSH_AF: begin
                            case (r_rdata[5:4])
                                P_BC:    c_pair = r_bc;
                                P_DE:    c_pair = r_de;
                                P_HL:    c_pair = r_hl;
                                default: c_pair = r_af;
                            endcase
                            c_acc = 1'b1; c_we = 1'b1; c_addr = r_sp - 16'd1;
                            c_wd = c_pair[15:8]; n_sp = r_sp - 16'd1; n_ret = S_PUSH_LO;
                        end
                        OPC_LD_HLSP: begin
                            c_acc = 1'b1; n_pc = r_pc + 16'd1; n_ret = S_LDHL_SP;
                        end
                        OPC_LD_SPHL: n_sp = r_hl;
                        default:     n_undef = 1'b1;
                    endcase
                end
            end
            S_LDR_WR: begin
                n_state = S_FIN; n_ret = S_FIN;
                if (r_opc[5:3] == R_MHL) begin
                    c_acc = 1'b1; c_we = 1'b1; c_addr = r_hl; c_wd = r_rdata;
                end else begin
                    c_set = 1'b1;
                end
            end
            S_LDA: begin
                n_af    = {r_rdata, r_af[7:0]};
                n_state = S_FIN;
            end
            S_HIGH: begin
                c_acc = 1'b1; c_addr = {HIGH_PAGE, r_rdata};
                c_we = (r_opc == OPC_STH_N);
                n_ret = (r_opc == OPC_STH_N) ? S_FIN : S_LDA;
            end
            S_IMM_LO: begin
                n_lo = r_rdata;
                c_acc = 1'b1; n_pc = r_pc + 16'd1; n_ret = S_IMM_HI;
            end
            S_IMM_HI: begin
                n_state = S_FIN; n_ret = S_FIN;
                case (r_opc)
                    OPC_LDI_BC: n_bc = c_word;
                    OPC_LDI_DE: n_de = c_word;
                    OPC_LDI_HL: n_hl = c_word;
                    OPC_LDI_SP: n_sp = c_word;
                    OPC_ST_NN: begin
                        c_acc = 1'b1; c_we = 1'b1; c_addr = c_word;
                    end
                    OPC_LD_NN: begin
                        c_acc = 1'b1; c_addr = c_word; n_ret = S_LDA;
                    end
                    default: begin
                        // store SP: low byte now, high byte at the next address
                        c_acc = 1'b1; c_we = 1'b1; c_addr = c_word; c_wd = r_sp[7:0];
                        n_ptr = c_word + 16'd1; n_ret = S_ST_SP_HI;
                    end
                endcase
            end
            S_ST_SP_HI: begin
                c_acc = 1'b1; c_we = 1'b1; c_addr = r_ptr; c_wd = r_sp[15:8];
                n_ret = S_FIN;
            end
            S_POP_LO: begin
                n_lo = r_rdata;
                c_acc = 1'b1; c_addr = r_sp; n_sp = r_sp + 16'd1; n_ret = S_POP_HI;
            end
            S_POP_HI: begin
                n_state = S_FIN;
                case (r_opc[5:4])
                    P_BC:    n_bc = c_word;
                    P_DE:    n_de = c_word;
                    P_HL:    n_hl = c_word;
                    default: n_af = c_word;
                endcase
            end
            S_PUSH_LO: begin
                case (r_opc[5:4])
                    P_BC:    c_pair = r_bc;
                    P_DE:    c_pair = r_de;
                    P_HL:    c_pair = r_hl;
                    default: c_pair = r_af;
                endcase
                c_acc = 1'b1; c_we = 1'b1; c_addr = r_sp - 16'd1; c_wd = c_pair[7:0];
                n_sp = r_sp - 16'd1; n_ret = S_FIN;
            end
            S_LDHL_SP: begin
                // Z and N cleared, H and C from the low byte of SP plus the offset
                n_hl = r_sp + {{8{r_rdata[7]}}, r_rdata};
                n_af = {r_af[15:8], 2'b00, c_hsum[4], c_csum[8], r_af[3:0]};
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_ov   = 1'b1;
                    n_o_rd = r_isrd ? r_rdata : 8'd0;
                    n_o_pc = r_pc; n_o_sp = r_sp;
                    n_o_af = r_af; n_o_bc = r_bc; n_o_de = r_de; n_o_hl = r_hl;
                    n_o_un = r_undef;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (c_set) begin
            case (c_set_code)
                R_B:     n_bc = {c_set_val, r_bc[7:0]};
                R_C:     n_bc = {r_bc[15:8], c_set_val};
                R_D:     n_de = {c_set_val, r_de[7:0]};
                R_E:     n_de = {r_de[15:8], c_set_val};
                R_H:     n_hl = {c_set_val, r_hl[7:0]};
                R_L:     n_hl = {r_hl[15:8], c_set_val};
                default: n_af = {c_set_val, r_af[7:0]};
            endcase
        end

        c_prod = 50'(c_addr) * 50'(RECIP);
        if (c_acc) begin
            n_addr  = c_addr;
            n_q     = c_prod[47:32];
            n_we    = c_we;
            n_wd    = c_wd;
            n_state = S_MEM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_FIN;
            r_ov    <= 1'b0;
            r_isrd  <= 1'b0;
            r_undef <= 1'b0;
            r_we    <= 1'b0;
            r_af <= '0; r_bc <= '0; r_de <= '0; r_hl <= '0; r_pc <= '0; r_sp <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ov    <= n_ov;
            r_isrd  <= n_isrd;
            r_undef <= n_undef;
            r_we    <= n_we;
            r_af <= n_af; r_bc <= n_bc; r_de <= n_de; r_hl <= n_hl; r_pc <= n_pc; r_sp <= n_sp;
        end
        r_addr <= n_addr; r_q <= n_q; r_wd <= n_wd;
        r_opc  <= n_opc;  r_lo <= n_lo; r_ptr <= n_ptr;
        r_o_rd <= n_o_rd; r_o_pc <= n_o_pc; r_o_sp <= n_o_sp;
        r_o_af <= n_o_af; r_o_bc <= n_o_bc; r_o_de <= n_o_de; r_o_hl <= n_o_hl;
        r_o_un <= n_o_un;
    end

endmodule

/* src/lsx_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsx_checker
// Port-level checks for the load/store executor.
// ----------------------------------------------------------------------------
module lsx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_read_data,
    input logic [15:0] i_prog_counter,
    input logic        i_undefined_op
);
    // one item in flight: no accept directly after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_prog_counter))
        else $error("stalled result changed");

    // undefined opcode only on execute, which never returns read data
    a_undef_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_undefined_op |-> i_read_data == 8'd0)
        else $error("read data with undefined opcode");
endmodule

bind cpu_load_store_executor_unit lsx_checker u_lsx_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_read_data    (o_out.read_data),
    .i_prog_counter (o_out.prog_counter),
    .i_undefined_op (o_out.undefined_op)
);
